FILE: src/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types and constants of the scrambled frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package sfr_pkg;

    // configuration port
    localparam int unsigned ADDR_W = 3;
    localparam int unsigned DATA_W = 32;
    localparam logic        REG_RATE_LIMIT = 1'b0;
    localparam logic        REG_IDLE_LIMIT = 1'b1;

    localparam logic [15:0] RATE_LIMIT_RST = 16'd100;
    localparam logic [7:0]  IDLE_LIMIT_RST = 8'd60;

    // framing
    localparam logic [15:0] HEADER_BYTES   = 16'd2;
    localparam logic [15:0] MIN_TOTAL_LEN  = 16'd8;
    localparam logic [15:0] IDX_ORDER_LO   = 16'd2;
    localparam logic [15:0] IDX_ORDER_HI   = 16'd3;
    localparam logic [15:0] IDX_ID_LO      = 16'd4;
    localparam logic [15:0] IDX_ID_HI      = 16'd5;
    localparam logic [15:0] BODY_HEAD      = 16'd6;
    localparam logic [15:0] SUM_GOOD       = 16'hFFFF;
    localparam logic [15:0] FRAMES_MAX     = 16'hFFFF;
    localparam logic [7:0]  IDLE_MAX       = 8'hFF;

    localparam logic        CMD_BYTE = 1'b0;

    typedef enum logic [1:0] {
        KIND_PAYLOAD  = 2'd0,
        KIND_FRAME_OK = 2'd1,
        KIND_ERROR    = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_LENGTH   = 3'd1,
        ERR_CHECKSUM = 3'd2,
        ERR_ORDER    = 3'd3,
        ERR_RATE     = 3'd4,
        ERR_IDLE     = 3'd5
    } t_err;

    typedef enum logic [2:0] {
        PH_LEN_LO = 3'b001,
        PH_LEN_HI = 3'b010,
        PH_BODY   = 3'b100
    } t_phase;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  payload_byte;
        logic [15:0] frame_id;
        t_err        error_code;
        logic        last;
    } t_result;

    // results produced by one transaction, in order
    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_push;

    typedef struct packed {
        logic [15:0] frame_rate_limit;
        logic [7:0]  idle_limit_seconds;
    } t_cfg;

    function automatic t_result make_result(t_kind kind, logic [7:0] pb,
                                            logic [15:0] mid, t_err err,
                                            logic last);
        t_result r;
        r.kind         = kind;
        r.payload_byte = pb;
        r.frame_id     = mid;
        r.error_code   = err;
        r.last         = last;
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: src/sfr_regs.sv
// ----------------------------------------------------------------------------
// sfr_regs
// Configuration registers behind a simple APB-style port.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_regs
    import sfr_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output t_cfg                   o_cfg
);

    t_cfg r_cfg;
    logic w_write;

    assign pready  = 1'b1;
    assign w_write = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_rate_limit   <= RATE_LIMIT_RST;
            r_cfg.idle_limit_seconds <= IDLE_LIMIT_RST;
        end else if (w_write) begin
            if (paddr[2] == REG_RATE_LIMIT) begin
                r_cfg.frame_rate_limit <= pwdata[15:0];
            end else begin
                r_cfg.idle_limit_seconds <= pwdata[7:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_IDLE_LIMIT) begin
            prdata = {24'd0, r_cfg.idle_limit_seconds};
        end else begin
            prdata = {16'd0, r_cfg.frame_rate_limit};
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

FILE: src/sfr_core.sv
// ----------------------------------------------------------------------------
// sfr_core
// Input register plus the per-item deframing, descramble, checksum and rate/idle policing logic.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_core
    import sfr_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic       i_cmd,
    input  wire logic [7:0] i_rx_byte,
    input  wire t_cfg       i_cfg,
    input  wire logic       i_room,
    output t_push           o_push,
    output logic            o_dead
);

    logic        r_in_valid;
    logic        r_cmd;
    logic [7:0]  r_rx_byte;

    t_phase      r_phase,          n_phase;
    logic [7:0]  r_length_low,     n_length_low;
    logic [15:0] r_body_remaining, n_body_remaining;
    logic [15:0] r_body_index,     n_body_index;
    logic [7:0]  r_seed,           n_seed;
    logic [15:0] r_sum,            n_sum;
    logic [7:0]  r_pending,        n_pending;
    logic [15:0] r_expected,       n_expected;
    logic [15:0] r_order,          n_order;
    logic [15:0] r_id,             n_id;
    logic [15:0] r_frames,         n_frames;
    logic [7:0]  r_idle,           n_idle;
    logic        r_seen,           n_seen;
    logic        r_dead,           n_dead;

    logic w_advance;

    assign o_stall   = r_in_valid && !i_room;
    assign w_advance = r_in_valid && i_room;
    assign o_dead    = r_dead;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_cmd     <= i_cmd;
            r_rx_byte <= i_rx_byte;
        end
    end

    always_comb begin
        logic [15:0] v_total;
        logic [7:0]  v_plain;
        logic [15:0] v_add;
        logic [16:0] v_sum17;
        logic [7:0]  v_idle_inc;
        logic        v_has_pay;
        logic        v_has_verdict;
        t_result     v_pay;
        t_result     v_verdict;

        n_phase          = r_phase;
        n_length_low     = r_length_low;
        n_body_remaining = r_body_remaining;
        n_body_index     = r_body_index;
        n_seed           = r_seed;
        n_sum            = r_sum;
        n_pending        = r_pending;
        n_expected       = r_expected;
        n_order          = r_order;
        n_id             = r_id;
        n_frames         = r_frames;
        n_idle           = r_idle;
        n_seen           = r_seen;
        n_dead           = r_dead;
        o_push           = '0;

        v_total       = {r_rx_byte, r_length_low};
        v_plain       = r_rx_byte ^ r_seed;
        v_add         = r_body_index[0] ? {v_plain, 8'd0} : {8'd0, v_plain};
        v_sum17       = {1'b0, r_sum} + {1'b0, v_add};
        v_idle_inc    = (r_idle == IDLE_MAX) ? r_idle : r_idle + 8'd1;
        v_has_pay     = 1'b0;
        v_has_verdict = 1'b0;
        v_pay         = '0;
        v_verdict     = '0;

        if (w_advance && !r_dead) begin
            if (r_cmd != CMD_BYTE) begin
                // one-second tick
                if (r_frames > i_cfg.frame_rate_limit) begin
                    n_dead       = 1'b1;
                    n_phase      = PH_LEN_LO;
                    o_push.count = 2'd1;
                    o_push.first = make_result(KIND_ERROR, 8'd0, 16'd0, ERR_RATE, 1'b1);
                end else begin
                    n_frames = '0;
                    if (r_seen) begin
                        n_idle = v_idle_inc;
                        if (v_idle_inc > i_cfg.idle_limit_seconds) begin
                            n_dead       = 1'b1;
                            n_phase      = PH_LEN_LO;
                            o_push.count = 2'd1;
                            o_push.first = make_result(KIND_ERROR, 8'd0, 16'd0,
                                                       ERR_IDLE, 1'b1);
                        end
                    end
                end
            end else begin
                case (r_phase)
                    PH_LEN_HI: begin
                        if (v_total < MIN_TOTAL_LEN) begin
                            n_dead       = 1'b1;
                            n_phase      = PH_LEN_LO;
                            o_push.count = 2'd1;
                            o_push.first = make_result(KIND_ERROR, 8'd0, 16'd0,
                                                       ERR_LENGTH, 1'b1);
                        end else begin
                            n_body_remaining = v_total - HEADER_BYTES;
                            n_body_index     = '0;
                            n_sum            = '0;
                            n_phase          = PH_BODY;
                        end
                    end
                    PH_BODY: begin
                        n_seed = r_seed + v_plain;
                        // end-around carry
                        n_sum  = v_sum17[16] ? v_sum17[15:0] + 16'd1 : v_sum17[15:0];
                        if (r_body_index == IDX_ORDER_LO || r_body_index == IDX_ID_LO) begin
                            n_pending = v_plain;
                        end else if (r_body_index == IDX_ORDER_HI) begin
                            n_order = {v_plain, r_pending};
                        end else if (r_body_index == IDX_ID_HI) begin
                            n_id = {v_plain, r_pending};
                        end
                        n_body_index     = r_body_index + 16'd1;
                        n_body_remaining = (r_body_remaining != '0) ?
                                           r_body_remaining - 16'd1 : '0;
                        if (r_body_index >= BODY_HEAD) begin
                            v_has_pay = 1'b1;
                            v_pay     = make_result(KIND_PAYLOAD, v_plain, 16'd0, ERR_NONE,
                                                    n_body_remaining != '0);
                        end
                        if (n_body_remaining == '0) begin
                            v_has_verdict = 1'b1;
                            n_phase       = PH_LEN_LO;
                            if (n_sum != SUM_GOOD) begin
                                n_dead    = 1'b1;
                                v_verdict = make_result(KIND_ERROR, 8'd0, 16'd0,
                                                        ERR_CHECKSUM, 1'b1);
                            end else if (n_order != r_expected) begin
                                n_dead    = 1'b1;
                                v_verdict = make_result(KIND_ERROR, 8'd0, 16'd0,
                                                        ERR_ORDER, 1'b1);
                            end else begin
                                n_expected = r_expected + 16'd1;
                                n_frames   = (r_frames == FRAMES_MAX) ?
                                             r_frames : r_frames + 16'd1;
                                n_idle     = '0;
                                n_seen     = 1'b1;
                                v_verdict  = make_result(KIND_FRAME_OK, 8'd0, n_id,
                                                         ERR_NONE, 1'b1);
                            end
                        end
                        if (v_has_pay) begin
                            o_push.first  = v_pay;
                            o_push.second = v_verdict;
                            o_push.count  = v_has_verdict ? 2'd2 : 2'd1;
                        end else begin
                            o_push.first  = v_verdict;
                            o_push.count  = {1'b0, v_has_verdict};
                        end
                    end
                    default: begin
                        n_length_low = r_rx_byte;
                        n_phase      = PH_LEN_HI;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase          <= PH_LEN_LO;
            r_length_low     <= '0;
            r_body_remaining <= '0;
            r_body_index     <= '0;
            r_seed           <= '0;
            r_sum            <= '0;
            r_pending        <= '0;
            r_expected       <= '0;
            r_order          <= '0;
            r_id             <= '0;
            r_frames         <= '0;
            r_idle           <= '0;
            r_seen           <= 1'b0;
            r_dead           <= 1'b0;
        end else begin
            r_phase          <= n_phase;
            r_length_low     <= n_length_low;
            r_body_remaining <= n_body_remaining;
            r_body_index     <= n_body_index;
            r_seed           <= n_seed;
            r_sum            <= n_sum;
            r_pending        <= n_pending;
            r_expected       <= n_expected;
            r_order          <= n_order;
            r_id             <= n_id;
            r_frames         <= n_frames;
            r_idle           <= n_idle;
            r_seen           <= n_seen;
            r_dead           <= n_dead;
        end
    end

endmodule

`default_nettype wire

FILE: src/sfr_outq.sv
// ----------------------------------------------------------------------------
// sfr_outq
// Result queue: takes up to two results per cycle, hands out one per cycle while not stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_outq
    import sfr_pkg::*;
#(
    parameter int unsigned DEPTH = 4
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_push i_push,
    output logic       o_room,
    output logic       o_valid,
    input  wire logic  i_stall,
    output t_result    o_result
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_result         r_mem [DEPTH];
    logic [PW-1:0]   r_wptr, n_wptr;
    logic [PW-1:0]   r_rptr, n_rptr;
    logic [CW-1:0]   r_count, n_count;
    logic [PW-1:0]   w_wptr_inc;
    logic            w_pop;

    function automatic logic [PW-1:0] ptr_inc(logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign o_valid    = (r_count != '0);
    assign o_result   = r_mem[r_rptr];
    assign w_pop      = o_valid && !i_stall;
    // leave space for the two results of a frame's final byte
    assign o_room     = (r_count <= CW'(DEPTH - 2));
    assign w_wptr_inc = ptr_inc(r_wptr);

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = w_pop ? ptr_inc(r_rptr) : r_rptr;
        n_count = r_count + CW'(i_push.count) - CW'(w_pop);
        if (i_push.count == 2'd1) begin
            n_wptr = w_wptr_inc;
        end else if (i_push.count == 2'd2) begin
            n_wptr = ptr_inc(w_wptr_inc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wptr] <= i_push.first;
        end
        if (i_push.count == 2'd2) begin
            r_mem[w_wptr_inc] <= i_push.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

FILE: src/scrambled_frame_receiver_unit.sv
// ----------------------------------------------------------------------------
// scrambled_frame_receiver_unit
// Deframer for a scrambled, length-prefixed stream with checksum, sequence
// and rate/idle policing.
// ----------------------------------------------------------------------------
// path: a result is offered once its transaction has passed the input register
// and then been written into the result queue
// throughput: one input transaction per cycle while not stalled; a frame's final
// byte can yield two results (its payload byte and the verdict), and the input
// stalls while the result queue has fewer than two free entries
// reset: synchronous active low; clears the control state, loads limits 100 and 60
`default_nettype none

module scrambled_frame_receiver_unit
    import sfr_pkg::*;
#(
    parameter int unsigned OUT_DEPTH = 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic              i_cmd,
    input  wire logic [7:0]        i_rx_byte,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic [1:0]             o_kind,
    output logic [7:0]             o_payload_byte,
    output logic [15:0]            o_frame_id,
    output logic [2:0]             o_error_code,
    output logic                   o_last,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready
);

    t_cfg    w_cfg;
    t_push   w_push;
    t_result w_head;
    logic    w_room;
    logic    w_dead;

    sfr_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    sfr_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_stall   (o_in_stall),
        .i_cmd     (i_cmd),
        .i_rx_byte (i_rx_byte),
        .i_cfg     (w_cfg),
        .i_room    (w_room),
        .o_push    (w_push),
        .o_dead    (w_dead)
    );

    sfr_outq #(
        .DEPTH (OUT_DEPTH)
    ) u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .o_room   (w_room),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_result (w_head)
    );

    assign o_kind         = w_head.kind;
    assign o_payload_byte = w_head.payload_byte;
    assign o_frame_id     = w_head.frame_id;
    assign o_error_code   = w_head.error_code;
    assign o_last         = w_head.last;

    // a closed connection produces nothing more
    a_dead_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_dead |-> (w_push.count == 2'd0))
        else $error("result produced on a closed connection");

    // an error report always ends its transaction
    a_error_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind == KIND_ERROR) |-> o_last)
        else $error("error result not marked last");

    // error code only travels with an error report
    a_code_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind != KIND_ERROR) |-> (o_error_code == ERR_NONE))
        else $error("error code on a non-error result");

    // once an error is delivered, the connection stays closed
    a_error_kills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_kind == KIND_ERROR) |=> w_dead)
        else $error("connection still open after an error");

endmodule

`default_nettype wire

FILE: verif/scrambled_frame_receiver_unit_test.sv
// ----------------------------------------------------------------------------
// scrambled_frame_receiver_unit_test
// Self-checking bench for the scrambled frame receiver. Frames are built with
// a valid checksum and sequence number, scrambled, and fed byte by byte with
// ticks in between. A predictor of the deframer computes the expected results
// for every accepted transaction. The limit registers are swept between
// phases, and the run ends by closing the connection on one randomly chosen
// error and then checking that the dead connection stays silent.
// ----------------------------------------------------------------------------
`default_nettype none

module scrambled_frame_receiver_unit_test;
    import sfr_pkg::*;

    localparam logic CMD_TICK = ~CMD_BYTE;
    localparam logic [ADDR_W-1:0] ADDR_RATE = {REG_RATE_LIMIT, 2'b00};
    localparam logic [ADDR_W-1:0] ADDR_IDLE = {REG_IDLE_LIMIT, 2'b00};

    typedef enum int {FLAW_NONE, FLAW_SUM, FLAW_ORDER} t_flaw;
    typedef enum logic [1:0] {
        STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE
    } t_stall_mode;

    typedef struct packed {
        logic       cmd;
        logic [7:0] rx;
    } t_rx_item;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              o_in_stall;
    logic              i_cmd = CMD_BYTE;
    logic [7:0]        i_rx_byte = 8'h00;
    logic              o_out_valid;
    logic              out_stall = 1'b0;
    logic [1:0]        o_kind;
    logic [7:0]        o_payload_byte;
    logic [15:0]       o_frame_id;
    logic [2:0]        o_error_code;
    logic              o_last;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    scrambled_frame_receiver_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (o_in_stall),
        .i_cmd          (i_cmd),
        .i_rx_byte      (i_rx_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (out_stall),
        .o_kind         (o_kind),
        .o_payload_byte (o_payload_byte),
        .o_frame_id     (o_frame_id),
        .o_error_code   (o_error_code),
        .o_last         (o_last),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // deframer predictor
    // ------------------------------------------------------------------
    logic [15:0] rate_cap = RATE_LIMIT_RST;
    logic [7:0]  idle_cap = IDLE_LIMIT_RST;

    t_phase      frame_phase = PH_LEN_LO;
    logic [7:0]  len_lo = '0;
    logic [15:0] body_left = '0;
    logic [15:0] body_pos = '0;
    logic [7:0]  descramble_seed = '0;
    logic [16:0] csum = '0;
    logic [7:0]  held_lo = '0;
    logic [15:0] want_order = '0;
    logic [15:0] got_order = '0;
    logic [15:0] got_id = '0;
    logic [15:0] frame_count = '0;
    logic [7:0]  idle_ticks = '0;
    logic        seen_good = 1'b0;
    logic        conn_dead = 1'b0;

    t_result expected_results[$];

    function automatic void push_result(t_kind kind, logic [7:0] pb, logic [15:0] mid,
                                        t_err err, logic last);
        t_result r;
        r.kind         = kind;
        r.payload_byte = pb;
        r.frame_id     = mid;
        r.error_code   = err;
        r.last         = last;
        expected_results.push_back(r);
    endfunction

    function automatic void close_connection(t_err code);
        conn_dead   = 1'b1;
        frame_phase = PH_LEN_LO;
        push_result(KIND_ERROR, 8'h00, 16'h0000, code, 1'b1);
    endfunction

    function automatic void deframe_step(logic cmd, logic [7:0] rx);
        logic [15:0] total;
        logic [15:0] pos;
        logic [7:0]  p;
        if (conn_dead)
            return;
        if (cmd != CMD_BYTE) begin
            if (frame_count > rate_cap) begin
                close_connection(ERR_RATE);
                return;
            end
            frame_count = '0;
            if (seen_good) begin
                if (idle_ticks != IDLE_MAX)
                    idle_ticks = idle_ticks + 8'd1;
                if (idle_ticks > idle_cap)
                    close_connection(ERR_IDLE);
            end
            return;
        end
        case (frame_phase)
            PH_LEN_HI: begin
                total = {rx, len_lo};
                if (total < MIN_TOTAL_LEN) begin
                    close_connection(ERR_LENGTH);
                    return;
                end
                body_left   = total - HEADER_BYTES;
                body_pos    = '0;
                csum        = '0;
                frame_phase = PH_BODY;
                return;
            end
            PH_BODY: ;
            default: begin
                len_lo      = rx;
                frame_phase = PH_LEN_HI;
                return;
            end
        endcase

        p = rx ^ descramble_seed;
        descramble_seed = descramble_seed + p;
        pos = body_pos;
        csum = csum + (pos[0] ? {1'b0, p, 8'h00} : {9'h000, p});
        if (csum[16])
            csum = {1'b0, csum[15:0]} + 17'd1;
        if (pos == IDX_ORDER_LO || pos == IDX_ID_LO)
            held_lo = p;
        else if (pos == IDX_ORDER_HI)
            got_order = {p, held_lo};
        else if (pos == IDX_ID_HI)
            got_id = {p, held_lo};
        body_pos = body_pos + 16'd1;
        if (body_left != 0)
            body_left = body_left - 16'd1;
        if (pos >= BODY_HEAD)
            push_result(KIND_PAYLOAD, p, 16'h0000, ERR_NONE, body_left != 0);
        if (body_left != 0)
            return;

        // frame verdict: checksum beats order
        frame_phase = PH_LEN_LO;
        if (csum[15:0] != SUM_GOOD) begin
            close_connection(ERR_CHECKSUM);
            return;
        end
        if (got_order != want_order) begin
            close_connection(ERR_ORDER);
            return;
        end
        want_order = want_order + 16'd1;
        if (frame_count != FRAMES_MAX)
            frame_count = frame_count + 16'd1;
        idle_ticks = '0;
        seen_good  = 1'b1;
        push_result(KIND_FRAME_OK, 8'h00, got_id, ERR_NONE, 1'b1);
    endfunction

    // ------------------------------------------------------------------
    // stream builder: mirrors the sender side of the link
    // ------------------------------------------------------------------
    t_rx_item    rx_queue[$];
    logic [7:0]  tx_seed = '0;
    logic [15:0] tx_order = '0;
    int          tx_good = 0;
    int          tx_idle = 0;
    bit          tx_seen = 1'b0;

    task automatic queue_byte(input logic [7:0] b);
        rx_queue.push_back({CMD_BYTE, b});
    endtask

    task automatic queue_tick();
        rx_queue.push_back({CMD_TICK, 8'($urandom)});
        tx_good = 0;
        if (tx_seen && tx_idle < 255)
            tx_idle++;
    endtask

    function automatic bit tick_is_safe();
        int next_idle;
        next_idle = (tx_idle < 255) ? tx_idle + 1 : 255;
        return (tx_good <= int'(rate_cap)) && !(tx_seen && next_idle > int'(idle_cap));
    endfunction

    // fill < 0 gives random payload with a bias toward 00 and ff
    task automatic queue_frame(input int total, input t_flaw flaw, input logic [15:0] id,
                               input int fill);
        logic [7:0]      plain[];
        longint unsigned acc;
        logic [15:0]     word0;
        logic [15:0]     order;
        logic [15:0]     total16;
        logic [7:0]      p;
        plain = new[total - 2];
        order = tx_order;
        if (flaw == FLAW_ORDER)
            order = tx_order + 16'($urandom_range(1, 65535));
        plain[2] = order[7:0];
        plain[3] = order[15:8];
        plain[4] = id[7:0];
        plain[5] = id[15:8];
        for (int i = 6; i < total - 2; i++) begin
            if (fill >= 0)
                plain[i] = 8'(fill);
            else if ($urandom_range(0, 7) == 0)
                plain[i] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            else
                plain[i] = 8'($urandom);
        end
        acc = 0;
        for (int i = 2; i < total - 2; i++)
            acc += (i % 2) ? (longint'(plain[i]) << 8) : longint'(plain[i]);
        // leading word makes the end-around sum come out all ones
        word0 = 16'(65535 - (acc % 65535));
        if (flaw == FLAW_SUM)
            word0 = word0 ^ (16'd1 << $urandom_range(0, 15));
        plain[0] = word0[7:0];
        plain[1] = word0[15:8];
        total16 = 16'(total);
        queue_byte(total16[7:0]);
        queue_byte(total16[15:8]);
        for (int i = 0; i < total - 2; i++) begin
            p = plain[i];
            queue_byte(p ^ tx_seed);
            tx_seed = tx_seed + p;
        end
        if (flaw == FLAW_NONE) begin
            tx_order = tx_order + 16'd1;
            tx_good++;
            tx_idle = 0;
            tx_seen = 1'b1;
        end
    endtask

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 19);
        if (r < 14)
            return $urandom_range(8, 16);
        if (r < 19)
            return $urandom_range(17, 64);
        return $urandom_range(65, 400);
    endfunction

    // ------------------------------------------------------------------
    // input driver: bursts with random gaps
    // ------------------------------------------------------------------
    t_rx_item next_item;
    int       burst_left = 1;
    int       gap_left = 0;
    int       items_accepted = 0;
    int       ticks_accepted = 0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5)
            return 0;
        if (r < 8)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !o_in_stall) begin
                deframe_step(i_cmd, i_rx_byte);
                items_accepted++;
                if (i_cmd != CMD_BYTE)
                    ticks_accepted++;
            end
            if (!in_valid || !o_in_stall) begin
                if (gap_left != 0) begin
                    in_valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end else if (rx_queue.size() != 0) begin
                    next_item = rx_queue.pop_front();
                    in_valid  <= 1'b1;
                    i_cmd     <= next_item.cmd;
                    i_rx_byte <= next_item.rx;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 48);
                        gap_left   <= pick_gap();
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // output stall pattern, with long hold-offs to back up the block
    // ------------------------------------------------------------------
    t_stall_mode stall_mode = STALL_NONE;
    int          mode_left = 0;
    int          hold_left = 0;
    int          pressure_asks = 0;
    int          pressure_served = 0;

    always @(posedge i_clk) begin
        int          next_hold;
        int          next_mode_left;
        t_stall_mode next_mode;
        next_hold      = 0;
        next_mode      = stall_mode;
        next_mode_left = mode_left;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else if (hold_left != 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (pressure_served != pressure_asks) begin
            pressure_served <= pressure_served + 1;
            hold_left       <= $urandom_range(150, 250);
            out_stall       <= 1'b1;
        end else begin
            if (mode_left == 0) begin
                next_mode      = t_stall_mode'($urandom_range(0, 3));
                next_mode_left = $urandom_range(16, 200);
            end else begin
                next_mode_left = mode_left - 1;
            end
            if ($urandom_range(0, 1999) == 0)
                next_hold = $urandom_range(40, 120);
            stall_mode <= next_mode;
            mode_left  <= next_mode_left;
            hold_left  <= next_hold;
            case (next_mode)
                STALL_NONE:   out_stall <= 1'b0;
                STALL_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY:  out_stall <= ($urandom_range(0, 9) < 7);
                default:      out_stall <= ~out_stall;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // result checker
    // ------------------------------------------------------------------
    t_result want;
    int      fail_count = 0;
    int      results_checked = 0;
    int      frames_ok = 0;
    int      close_code = 0;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !out_stall) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result: kind %0d payload %0h id %0h code %0d last %0d",
                       o_kind, o_payload_byte, o_frame_id, o_error_code, o_last);
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                results_checked++;
                if (o_kind !== want.kind) begin
                    $error("kind: expected %0d, actual %0d", want.kind, o_kind);
                    fail_count++;
                end
                if (o_payload_byte !== want.payload_byte) begin
                    $error("payload_byte: expected %0h, actual %0h",
                           want.payload_byte, o_payload_byte);
                    fail_count++;
                end
                if (o_frame_id !== want.frame_id) begin
                    $error("frame_id: expected %0h, actual %0h",
                           want.frame_id, o_frame_id);
                    fail_count++;
                end
                if (o_error_code !== want.error_code) begin
                    $error("error_code: expected %0d, actual %0d",
                           want.error_code, o_error_code);
                    fail_count++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %0d, actual %0d", want.last, o_last);
                    fail_count++;
                end
                if (want.kind == KIND_FRAME_OK)
                    frames_ok++;
                if (want.kind == KIND_ERROR)
                    close_code = want.error_code;
            end
        end
    end

    // ------------------------------------------------------------------
    // register access and sequencing
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] value);
        logic [DATA_W-1:0] got;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        psel    <= 1'b1;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== value) begin
            $error("register %0h readback: expected %0h, actual %0h", addr, value, got);
            fail_count++;
        end
    endtask

    task automatic set_limits(input logic [15:0] rate, input logic [7:0] idle);
        rate_cap = rate;
        idle_cap = idle;
        write_reg(ADDR_RATE, DATA_W'(rate));
        write_reg(ADDR_IDLE, DATA_W'(idle));
    endtask

    // wait for the block to drain, plus its latency
    task automatic wait_idle();
        while (rx_queue.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    initial begin
        int   random_items;
        int   target;
        int   n;
        int   len;
        int   r;
        int   extra;
        t_err close_plan;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // directed: reset limits, tick before any frame, frames of length 8 and 9
        queue_tick();
        queue_frame(8, FLAW_NONE, 16'hFFFF, -1);
        queue_frame(9, FLAW_NONE, 16'h0000, 8'hFF);
        queue_tick();
        wait_idle();

        // random frames under a sweep of limits
        random_items = 0;
        while (random_items < 950) begin
            wait_idle();
            case ($urandom_range(0, 4))
                0:       rate_cap = 16'd0;
                1:       rate_cap = 16'hFFFF;
                2:       rate_cap = 16'($urandom_range(1, 4));
                default: rate_cap = 16'($urandom_range(5, 300));
            endcase
            case ($urandom_range(0, 4))
                0:       idle_cap = 8'd1;
                1:       idle_cap = 8'd255;
                2:       idle_cap = 8'($urandom_range(2, 5));
                default: idle_cap = 8'($urandom_range(6, 254));
            endcase
            set_limits(rate_cap, idle_cap);
            target = $urandom_range(60, 180);
            n = 0;
            while (n < target) begin
                if ($urandom_range(0, 5) == 0) begin
                    if (tick_is_safe()) begin
                        queue_tick();
                        n++;
                    end
                end else begin
                    len = pick_len();
                    queue_frame(len, FLAW_NONE, 16'($urandom), -1);
                    n += len;
                end
            end
            if (random_items == 0)
                pressure_asks <= pressure_asks + 1;
            random_items += n;
        end

        // idle counter saturates when the limit is at its top
        wait_idle();
        set_limits(16'hFFFF, 8'd255);
        queue_frame(12, FLAW_NONE, 16'($urandom), -1);
        repeat (260) queue_tick();
        queue_frame($urandom_range(8, 20), FLAW_NONE, 16'($urandom), -1);
        wait_idle();

        // close the connection on one error, chosen per seed
        close_plan = t_err'($urandom_range(ERR_LENGTH, ERR_IDLE));
        case (close_plan)
            ERR_LENGTH: begin
                queue_byte(8'($urandom_range(0, 7)));
                queue_byte(8'h00);
            end
            ERR_CHECKSUM:
                queue_frame(pick_len(), FLAW_SUM, 16'($urandom), -1);
            ERR_ORDER:
                queue_frame(pick_len(), FLAW_ORDER, 16'($urandom), -1);
            ERR_RATE: begin
                r = $urandom_range(0, 3);
                set_limits(16'(r), 8'd255);
                extra = r + 1 - tx_good;
                for (int i = 0; i < extra; i++)
                    queue_frame(pick_len(), FLAW_NONE, 16'($urandom), -1);
                queue_tick();
            end
            default: begin
                r = $urandom_range(1, 4);
                set_limits(16'hFFFF, 8'(r));
                queue_frame(pick_len(), FLAW_NONE, 16'($urandom), -1);
                repeat (r + 1) queue_tick();
            end
        endcase
        // dead connection must stay silent
        repeat (40) rx_queue.push_back({1'($urandom), 8'($urandom)});

        while (rx_queue.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (400) @(posedge i_clk);

        $display("%0d transactions in (%0d ticks), %0d results checked, %0d frames accepted",
                 items_accepted, ticks_accepted, results_checked, frames_ok);
        $display("limits swept over both extremes; connection closed with code %0d",
                 close_code);
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #120_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
